// ===== design/ioevr_pkg.sv =====
// Package for the I/O event delta varint recorder.
// Shared widths, record type, queue status type, register index and back-end state type.
// No dependencies.
package ioevr_pkg;

    // Tick difference width, capped at the 32-bit tick field width
    localparam int TICK_BITS = 32;
    localparam int TICK_W    = 32;
    localparam int DIFF_W    = (TICK_BITS >= TICK_W) ? TICK_W : TICK_BITS;
    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int DIGIT_W   = 7;

    // APB register file: one 32-bit register at byte address 0
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_IDX_RECORDING_ENABLED = '0;

    // Record queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [DIFF_W-1:0] delta;
        logic [ADDR_W-1:0] port_address;
        logic [DATA_W-1:0] port_data;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VARINT,
        ST_ADDR_LO,
        ST_ADDR_HI,
        ST_DATA
    } back_state_t;

endpackage

// ===== design/ioevr_if.sv =====
// Handshake interfaces for the recorder: event input and byte output.
// Depends on ioevr_pkg for field widths.
interface ioevr_event_if;
    logic                         valid;
    logic                         ready;
    logic [ioevr_pkg::TICK_W-1:0] tick;
    logic [ioevr_pkg::ADDR_W-1:0] port_address;
    logic [ioevr_pkg::DATA_W-1:0] port_data;

    modport source (output valid, output tick, output port_address, output port_data,
                    input ready);
    modport sink   (input valid, input tick, input port_address, input port_data,
                    output ready);
endinterface

interface ioevr_byte_if;
    logic                         valid;
    logic                         ready;
    logic [ioevr_pkg::BYTE_W-1:0] out_byte;
    logic                         last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== design/ioevr_front.sv =====
// Front end: holds the enable and tick state, accepts events and forms records.
// Depends on ioevr_pkg and ioevr_if.
module ioevr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    ioevr_event_if.sink          evt,
    input  logic                 enable_wr,
    input  logic                 enable_val,
    output logic                 enable,
    input  ioevr_pkg::q_status_t q_status,
    output logic                 push,
    output ioevr_pkg::rec_t      push_rec
);

    logic                         enable_reg;
    logic                         have_first_reg;
    logic [ioevr_pkg::TICK_W-1:0] prev_tick_reg;
    logic [ioevr_pkg::TICK_W-1:0] base_tick;
    logic [ioevr_pkg::TICK_W-1:0] diff;

    // Disabled: everything is taken and dropped
    assign evt.ready = !enable_reg || !q_status.full;
    assign push      = evt.valid && evt.ready && enable_reg;
    assign enable    = enable_reg;

    // First recorded event measures against itself
    assign base_tick = have_first_reg ? prev_tick_reg : evt.tick;
    assign diff      = evt.tick - base_tick;

    assign push_rec.delta        = diff[ioevr_pkg::DIFF_W-1:0];
    assign push_rec.port_address = evt.port_address;
    assign push_rec.port_data    = evt.port_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            have_first_reg <= 1'b0;
            prev_tick_reg  <= '0;
        end
        else if (enable_wr)
        begin
            if (enable_val && !enable_reg)
            begin
                have_first_reg <= 1'b0;
            end
            enable_reg <= enable_val;
        end
        else if (push)
        begin
            have_first_reg <= 1'b1;
            prev_tick_reg  <= evt.tick;
        end
    end

endmodule

// ===== design/ioevr_queue.sv =====
// Short record queue decoupling the front end from the byte serialiser.
// Depends on ioevr_pkg.
module ioevr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ioevr_pkg::rec_t      push_rec,
    input  logic                 pop,
    output ioevr_pkg::rec_t      pop_rec,
    output ioevr_pkg::q_status_t q_status
);

    ioevr_pkg::rec_t              mem_reg [ioevr_pkg::QUEUE_DEPTH];
    logic [ioevr_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [ioevr_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [ioevr_pkg::QCNT_W-1:0] cnt_reg;
    logic [ioevr_pkg::QCNT_W-1:0] cnt_next;

    assign q_status.empty = (cnt_reg == '0);
    assign q_status.full  = (cnt_reg == ioevr_pkg::QCNT_W'(ioevr_pkg::QUEUE_DEPTH));
    assign pop_rec        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/ioevr_back.sv =====
// Back end: serialises one record a time into varint delta, address and data bytes.
// Depends on ioevr_pkg and ioevr_if.
module ioevr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ioevr_pkg::q_status_t q_status,
    input  ioevr_pkg::rec_t      pop_rec,
    output logic                 pop,
    ioevr_byte_if.source         rec
);

    ioevr_pkg::back_state_t       state_reg, state_next;
    logic [ioevr_pkg::DIFF_W-1:0] val_reg, val_next;
    logic [ioevr_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ioevr_pkg::DATA_W-1:0] data_reg, data_next;
    logic                         out_valid_reg, out_valid_next;
    logic [ioevr_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                         out_last_reg, out_last_next;
    logic                         slot_free;
    logic                         more;

    assign rec.valid    = out_valid_reg;
    assign rec.out_byte = out_byte_reg;
    assign rec.last     = out_last_reg;

    // Output slot can be loaded when empty or being drained this cycle
    assign slot_free = !out_valid_reg || rec.ready;
    assign more      = |val_reg[ioevr_pkg::DIFF_W-1:ioevr_pkg::DIGIT_W];

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && !rec.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;

        case (state_reg)
            ioevr_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    val_next   = pop_rec.delta;
                    addr_next  = pop_rec.port_address;
                    data_next  = pop_rec.port_data;
                    state_next = ioevr_pkg::ST_VARINT;
                end
            end
            ioevr_pkg::ST_VARINT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {more, val_reg[ioevr_pkg::DIGIT_W-1:0]};
                    out_last_next  = 1'b0;
                    val_next       = val_reg >> ioevr_pkg::DIGIT_W;
                    if (!more)
                    begin
                        state_next = ioevr_pkg::ST_ADDR_LO;
                    end
                end
            end
            ioevr_pkg::ST_ADDR_LO:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = addr_reg[7:0];
                    out_last_next  = 1'b0;
                    state_next     = ioevr_pkg::ST_ADDR_HI;
                end
            end
            ioevr_pkg::ST_ADDR_HI:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = addr_reg[15:8];
                    out_last_next  = 1'b0;
                    state_next     = ioevr_pkg::ST_DATA;
                end
            end
            ioevr_pkg::ST_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg;
                    out_last_next  = 1'b1;
                    // chain straight into the next queued record
                    if (!q_status.empty)
                    begin
                        pop        = 1'b1;
                        val_next   = pop_rec.delta;
                        addr_next  = pop_rec.port_address;
                        data_next  = pop_rec.port_data;
                        state_next = ioevr_pkg::ST_VARINT;
                    end
                    else
                    begin
                        state_next = ioevr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ioevr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        addr_reg     <= addr_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ioevr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/io_event_delta_varint_recorder.sv =====
// Top level of the I/O event delta varint recorder: APB register, front, queue, back.
// Depends on ioevr_pkg, ioevr_if, ioevr_front, ioevr_queue and ioevr_back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  evt     | in  | valid/ready        | tick[31:0], port_address[15:0],
//          |     |                    | port_data[7:0]
//  rec     | out | valid/ready        | out_byte[7:0], last
//  apb     | in  | psel/penable/pready| paddr[2:0], pwdata/prdata[31:0]
//
// Each recorded event yields 4 to 8 byte transactions (varint delta of 1 to 5
// bytes, then address low, address high, data); the back end sends one byte
// per cycle while the output is not stalled, and starts the next record back
// to back when the queue holds it.
// The front end accepts an event as soon as it is offered and stalls only
// while the two-entry record queue is full. Events arriving while recording
// is off are taken at once and dropped.
// Reset is asynchronous, active low, and clears the enable, tick state, queue
// and output valid; no clearing pass is needed.
module io_event_delta_varint_recorder (
    input  logic                          clk,
    input  logic                          rst_n,
    ioevr_event_if.sink                   evt,
    ioevr_byte_if.source                  rec,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ioevr_pkg::PADDR_W-1:0] paddr,
    input  logic [ioevr_pkg::PDATA_W-1:0] pwdata,
    output logic [ioevr_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);

    logic                 enable;
    logic                 enable_wr;
    logic                 push;
    logic                 pop;
    ioevr_pkg::rec_t      push_rec;
    ioevr_pkg::rec_t      pop_rec;
    ioevr_pkg::q_status_t q_status;

    // Register decode: word index from paddr, only recording_enabled exists
    assign pready    = 1'b1;
    assign enable_wr = psel && penable && pwrite && pready &&
                       (paddr[ioevr_pkg::PADDR_W-1:2] == ioevr_pkg::REG_IDX_RECORDING_ENABLED);
    assign prdata    = (paddr[ioevr_pkg::PADDR_W-1:2] == ioevr_pkg::REG_IDX_RECORDING_ENABLED)
                       ? {{(ioevr_pkg::PDATA_W-1){1'b0}}, enable}
                       : '0;

    // Front: enable/tick state, delta, push into queue
    ioevr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .enable_wr  (enable_wr),
        .enable_val (pwdata[0]),
        .enable     (enable),
        .q_status   (q_status),
        .push       (push),
        .push_rec   (push_rec)
    );

    ioevr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .q_status (q_status)
    );

    // Back: byte serialiser with output register
    ioevr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_rec  (pop_rec),
        .pop      (pop),
        .rec      (rec)
    );

endmodule

// ===== design/ioevr_checker.sv =====
// Port-level assertions for the recorder, bound to the top level.
// Depends on io_event_delta_varint_recorder (bind target).
module ioevr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       evt_ready,
    input logic       rec_valid,
    input logic       rec_ready,
    input logic [7:0] rec_out_byte,
    input logic       rec_last,
    input logic       enabled,
    input logic       rd_spare,
    input logic       pready
);

    // Held output byte must not change while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> rec_valid && $stable(rec_out_byte) && $stable(rec_last))
        else $error("output transaction changed while stalled");

    // Enable register reads back low: events are always taken and dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        !rd_spare && !enabled |-> evt_ready)
        else $error("event stalled while recording disabled");

    // Output slot is empty once reset has been seen
    assert property (@(posedge clk)
        !rst_n |=> !rec_valid)
        else $error("output valid during reset");

    // Register port never inserts a wait state
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind io_event_delta_varint_recorder ioevr_checker u_ioevr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt_ready    (evt.ready),
    .rec_valid    (rec.valid),
    .rec_ready    (rec.ready),
    .rec_out_byte (rec.out_byte),
    .rec_last     (rec.last),
    .enabled      (prdata[0]),
    .rd_spare     (paddr[2]),
    .pready       (pready)
);
